@@ sv/laft_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laft_pkg
// shared types and constants of the learned address forwarding table
// ----------------------------------------------------------------------------
package laft_pkg;

  localparam int ADDR_W   = 16;
  localparam int PORT_W   = 4;
  localparam int MASK_W   = 16;
  localparam int OUTC_W   = 3;

  localparam int DEF_PORT_COUNT       = 16;
  localparam int DEF_ENTRIES_PER_PORT = 40;

  localparam logic [ADDR_W-1:0] EMPTY_ADDR = 16'h0000;

  localparam logic CMD_LEARN  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [OUTC_W-1:0] {
    OUT_LOOKUP  = 3'd0,
    OUT_PRESENT = 3'd1,
    OUT_FREE    = 3'd2,
    OUT_EVICT   = 3'd3,
    OUT_IGNORED = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ sv/laft_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laft_ifs
// valid/ready channels for request and result transactions
// ----------------------------------------------------------------------------
interface laft_in_if import laft_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [PORT_W-1:0] port;
  logic [ADDR_W-1:0] node_address;

  modport source (output valid, cmd, port, node_address, input ready);
  modport sink   (input valid, cmd, port, node_address, output ready);
endinterface

interface laft_out_if import laft_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] port_mask;
  logic [OUTC_W-1:0] learn_outcome;

  modport source (output valid, port_mask, learn_outcome, input ready);
  modport sink   (input valid, port_mask, learn_outcome, output ready);
endinterface

@@ sv/laft_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laft_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module laft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

@@ sv/laft_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laft_ctrl
// sequencer: accept, slot scan, compare drain, commit of the result
// ----------------------------------------------------------------------------
module laft_ctrl import laft_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat.out_busy) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_FINISH: begin
        cmd.commit = !stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ sv/laft_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laft_dp
// per-port address rams, fill and oldest pointers, match and result register
// ----------------------------------------------------------------------------
module laft_dp import laft_pkg::*; #(
  parameter int PORT_COUNT       = DEF_PORT_COUNT,
  parameter int ENTRIES_PER_PORT = DEF_ENTRIES_PER_PORT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  output dp_stat_t          stat,
  input  logic              in_cmd,
  input  logic [PORT_W-1:0] in_port,
  input  logic [ADDR_W-1:0] in_node_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MASK_W-1:0] out_port_mask,
  output logic [OUTC_W-1:0] out_learn_outcome
);

  localparam int SW = $clog2(ENTRIES_PER_PORT);
  localparam int FW = $clog2(ENTRIES_PER_PORT + 1);
  localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

  logic              cmd_r;
  logic [PORT_W-1:0] port_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SW-1:0]     idx_r;
  logic              cmp_en_r;
  logic [SW-1:0]     cmp_idx_r;
  logic [PORT_COUNT-1:0] mask_r;
  logic [FW-1:0]     fill_r   [PORT_COUNT];
  logic [SW-1:0]     oldest_r [PORT_COUNT];
  logic [ADDR_W-1:0] rdata    [PORT_COUNT];
  logic [PORT_COUNT-1:0] hit;
  logic [PORT_COUNT-1:0] we;

  logic              out_valid_r;
  logic [MASK_W-1:0] out_mask_r;
  logic [OUTC_W-1:0] out_outcome_r;

  logic [PW-1:0]     pidx;
  logic              learn_ok;
  logic              present;
  logic              full;
  logic [SW-1:0]     waddr;
  outcome_t          outcome;

  assign pidx     = port_r[PW-1:0];
  assign learn_ok = (cmd_r == CMD_LEARN) && (addr_r != EMPTY_ADDR)
                    && (int'(port_r) < PORT_COUNT);
  assign present  = mask_r[pidx];
  assign full     = fill_r[pidx] == FW'(ENTRIES_PER_PORT);
  assign waddr    = full ? oldest_r[pidx] : fill_r[pidx][SW-1:0];

  always_comb begin
    if (cmd_r == CMD_LOOKUP) begin
      outcome = OUT_LOOKUP;
    end else if (!learn_ok) begin
      outcome = OUT_IGNORED;
    end else if (present) begin
      outcome = OUT_PRESENT;
    end else if (!full) begin
      outcome = OUT_FREE;
    end else begin
      outcome = OUT_EVICT;
    end
  end

  genvar p;
  generate
    for (p = 0; p < PORT_COUNT; p++) begin : g_port
      assign hit[p] = cmp_en_r && (FW'(cmp_idx_r) < fill_r[p])
                      && (rdata[p] == addr_r) && (addr_r != EMPTY_ADDR);
      assign we[p]  = cmd.commit && learn_ok && !present && (pidx == PW'(p));

      laft_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (ENTRIES_PER_PORT)
      ) u_ram (
        .clk     (clk),
        .we      (we[p]),
        .waddr   (waddr),
        .wdata   (addr_r),
        .raddr   (idx_r),
        .rdata_r (rdata[p])
      );

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          fill_r[p]   <= '0;
          oldest_r[p] <= '0;
        end else if (we[p]) begin
          if (!full) begin
            fill_r[p] <= fill_r[p] + 1'b1;
          end else if (oldest_r[p] == SW'(ENTRIES_PER_PORT - 1)) begin
            oldest_r[p] <= '0;
          end else begin
            oldest_r[p] <= oldest_r[p] + 1'b1;
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      port_r <= in_port;
      addr_r <= in_node_address;
    end
    if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.scan) begin
      idx_r <= idx_r + 1'b1;
    end
    cmp_idx_r <= idx_r;
    if (cmd.load) begin
      mask_r <= '0;
    end else if (cmp_en_r) begin
      mask_r <= mask_r | hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.scan;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_mask_r    <= (cmd_r == CMD_LOOKUP) ? MASK_W'(mask_r) : '0;
      out_outcome_r <= outcome;
    end
  end

  assign stat.scan_last = idx_r == SW'(ENTRIES_PER_PORT - 1);
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign out_valid         = out_valid_r;
  assign out_port_mask     = out_mask_r;
  assign out_learn_outcome = out_outcome_r;

endmodule

@@ sv/learned_address_forwarding_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// learned_address_forwarding_table_core
// learned per-port address lists with fifo replacement and lookup mask
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one request transaction: cmd (learn or lookup), port and
//   node_address. out_ch returns exactly one transaction per request:
//   port_mask (lookup hits, zero for learn) and learn_outcome.
//   each port keeps its list in its own ram; all ports are scanned side by
//   side, one slot per cycle; after the scan, a drain step and the commit
//   step the result goes into the output register. a new request is taken
//   once the previous one is committed, as the slot scan runs through the
//   single read port of each ram; one request is in work at a time.
//   the result sits in an output register; the next request is accepted
//   while it waits. if out_ch stalls, the following request finishes its
//   scan and holds in the commit step until the register frees.
//   reset clears the fill counts and oldest pointers, so all lists are
//   empty at once; no clearing pass over the rams is needed.
// ----------------------------------------------------------------------------
module learned_address_forwarding_table_core import laft_pkg::*; #(
  parameter int PORT_COUNT       = DEF_PORT_COUNT,
  parameter int ENTRIES_PER_PORT = DEF_ENTRIES_PER_PORT
) (
  input  logic        clk,
  input  logic        rst_n,
  laft_in_if.sink     in_ch,
  laft_out_if.source  out_ch
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  laft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  laft_dp #(
    .PORT_COUNT       (PORT_COUNT),
    .ENTRIES_PER_PORT (ENTRIES_PER_PORT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_cmd            (in_ch.cmd),
    .in_port           (in_ch.port),
    .in_node_address   (in_ch.node_address),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_port_mask     (out_ch.port_mask),
    .out_learn_outcome (out_ch.learn_outcome)
  );

endmodule

@@ bench/learned_address_forwarding_table_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// learned_address_forwarding_table_core_tb
// self-checking bench for the learned address forwarding table: learn and
// lookup requests go in over the request channel, and each result is
// compared with a local copy of the per-port address lists kept in step
// with every accepted request, under several idle and stall patterns
// ----------------------------------------------------------------------------
module learned_address_forwarding_table_core_tb;
  import laft_pkg::*;

  localparam int PORTS = DEF_PORT_COUNT;
  localparam int SLOTS = DEF_ENTRIES_PER_PORT;
  localparam int POOL  = 128;

  typedef struct packed {
    logic [MASK_W-1:0] port_mask;
    outcome_t          outcome;
  } table_result_t;

  logic clk;
  logic rst_n;

  laft_in_if  in_ch ();
  laft_out_if out_ch ();

  learned_address_forwarding_table_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local copy of the learned lists
  logic [ADDR_W-1:0] node_list [PORTS][SLOTS];
  int                list_fill [PORTS];
  int                list_oldest [PORTS];

  table_result_t     expected_results [$];
  table_result_t     oldest_expected;
  int                mismatch_count;
  int                requests_sent;
  int                outcome_seen [5];
  int                multi_port_hits;

  int                send_idle_pct;
  int                recv_stall_pct;
  int                hold_left;

  logic [ADDR_W-1:0] addr_pool [POOL];
  logic [PORT_W-1:0] hot_ports [3];

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic list_has(int p, logic [ADDR_W-1:0] a);
    for (int s = 0; s < list_fill[p]; s++)
      if (node_list[p][s] == a) return 1'b1;
    return 1'b0;
  endfunction

  function automatic table_result_t forward_or_learn(logic c, logic [PORT_W-1:0] p,
                                                     logic [ADDR_W-1:0] a);
    table_result_t r;
    r.port_mask = '0;
    r.outcome   = OUT_LOOKUP;
    if (c == CMD_LOOKUP) begin
      if (a != EMPTY_ADDR)
        for (int q = 0; q < PORTS; q++)
          if (list_has(q, a)) r.port_mask[q] = 1'b1;
    end else if (a == EMPTY_ADDR || int'(p) >= PORTS) begin
      r.outcome = OUT_IGNORED;
    end else if (list_has(p, a)) begin
      r.outcome = OUT_PRESENT;
    end else if (list_fill[p] < SLOTS) begin
      node_list[p][list_fill[p]] = a;
      list_fill[p]++;
      r.outcome = OUT_FREE;
    end else begin
      node_list[p][list_oldest[p]] = a;
      list_oldest[p] = (list_oldest[p] + 1) % SLOTS;
      r.outcome = OUT_EVICT;
    end
    return r;
  endfunction

  // result channel ready, with long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual mask %h outcome %0d",
                 $time, out_ch.port_mask, out_ch.learn_outcome);
        mismatch_count++;
      end else begin
        oldest_expected = expected_results.pop_front();
        if (out_ch.port_mask !== oldest_expected.port_mask ||
            out_ch.learn_outcome !== oldest_expected.outcome) begin
          $display("%0t mismatch: expected mask %h outcome %0d, actual mask %h outcome %0d",
                   $time, oldest_expected.port_mask, oldest_expected.outcome,
                   out_ch.port_mask, out_ch.learn_outcome);
          mismatch_count++;
        end
        if (out_ch.learn_outcome <= OUT_IGNORED) outcome_seen[out_ch.learn_outcome]++;
        if ($countones(out_ch.port_mask) > 1) multi_port_hits++;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic c, input logic [PORT_W-1:0] p,
                              input logic [ADDR_W-1:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= c;
    in_ch.port         <= p;
    in_ch.node_address <= a;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    expected_results.push_back(forward_or_learn(c, p, a));
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic test_special_cases();
    send_request(CMD_LOOKUP, 4'd0, 16'h1234);
    send_request(CMD_LEARN, 4'd0, EMPTY_ADDR);
    send_request(CMD_LOOKUP, 4'd15, EMPTY_ADDR);
    send_request(CMD_LEARN, 4'd0, 16'h0001);
    send_request(CMD_LEARN, 4'd0, 16'h0001);
    send_request(CMD_LEARN, 4'd15, 16'hFFFF);
    send_request(CMD_LEARN, 4'd15, 16'h0001);
    send_request(CMD_LOOKUP, 4'd0, 16'h0001);
    send_request(CMD_LOOKUP, 4'd7, 16'hFFFF);
    send_request(CMD_LEARN, 4'd15, 16'hFFFF);
    send_request(CMD_LEARN, 4'd3, 16'h5A5A);
    send_request(CMD_LEARN, 4'd12, 16'h5A5A);
    send_request(CMD_LEARN, 4'd8, 16'h8000);
    send_request(CMD_LOOKUP, 4'd15, 16'h5A5A);
    send_request(CMD_LOOKUP, 4'd0, 16'hA5A5);
    send_request(CMD_LOOKUP, 4'd0, 16'h8000);
    send_request(CMD_LEARN, 4'd15, EMPTY_ADDR);
  endtask

  // fill one port past its capacity so the oldest entries get replaced
  task automatic test_port_overflow();
    logic [ADDR_W-1:0] fresh [SLOTS+6];
    logic [PORT_W-1:0] p;
    p = PORT_W'($urandom_range(PORTS-1));
    foreach (fresh[i]) fresh[i] = ADDR_W'($urandom_range(16'hFFFF, 1));
    foreach (fresh[i]) send_request(CMD_LEARN, p, fresh[i]);
    for (int i = 0; i < 8; i++)
      send_request(CMD_LOOKUP, PORT_W'($urandom_range(15)), fresh[i]);
    send_request(CMD_LOOKUP, p, fresh[SLOTS+5]);
    send_request(CMD_LEARN, p, fresh[0]);
  endtask

  task automatic run_mixed_traffic(input int n_items);
    logic              c;
    logic [PORT_W-1:0] p;
    logic [ADDR_W-1:0] a;
    int                roll;
    for (int i = 0; i < n_items; i++) begin
      c = ($urandom_range(99) < 55) ? CMD_LEARN : CMD_LOOKUP;
      p = $urandom_range(1) ? hot_ports[$urandom_range(2)]
                            : PORT_W'($urandom_range(15));
      roll = $urandom_range(99);
      if (roll < 3) a = EMPTY_ADDR;
      else if (roll < 15) a = ADDR_W'($urandom_range(16'hFFFF));
      else a = addr_pool[$urandom_range(POOL-1)];
      send_request(c, p, a);
    end
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  run_mixed_traffic(340);
    send_idle_pct = 63; recv_stall_pct = 0;  run_mixed_traffic(340);
    send_idle_pct = 0;  recv_stall_pct = 63; run_mixed_traffic(340);
    send_idle_pct = 36; recv_stall_pct = 36; run_mixed_traffic(340);
  endtask

  // result side holds off while requests keep coming, so the input stalls
  task automatic test_result_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_left = 400;
    @(negedge clk);
    run_mixed_traffic(40);
  endtask

  // sender waits for the table to go quiet between bursts
  task automatic test_drain_pause();
    send_idle_pct  = 10;
    recv_stall_pct = 20;
    for (int b = 0; b < 2; b++) begin
      run_mixed_traffic(30);
      in_ch.valid <= 1'b0;
      wait (expected_results.size() == 0);
      @(negedge clk);
    end
  endtask

  initial begin
    int guard;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_LEARN;
    in_ch.port         = '0;
    in_ch.node_address = EMPTY_ADDR;
    out_ch.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_left          = 0;
    mismatch_count     = 0;
    requests_sent      = 0;
    multi_port_hits    = 0;
    foreach (outcome_seen[i]) outcome_seen[i] = 0;
    foreach (list_fill[p]) begin
      list_fill[p]   = 0;
      list_oldest[p] = 0;
      foreach (node_list[p][s]) node_list[p][s] = EMPTY_ADDR;
    end
    foreach (addr_pool[i]) addr_pool[i] = ADDR_W'($urandom_range(16'hFFFF, 1));
    foreach (hot_ports[i]) hot_ports[i] = PORT_W'($urandom_range(PORTS-1));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_special_cases();
    test_port_overflow();
    test_idle_phases();
    test_result_backpressure();
    test_drain_pause();

    in_ch.valid <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 200_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SLOTS + 20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t missing results: %0d transactions never returned",
               $time, expected_results.size());
      mismatch_count++;
    end

    $display("covered %0d requests: %0d lookups (%0d multi-port hits), %0d inserts,",
             requests_sent, outcome_seen[OUT_LOOKUP], multi_port_hits,
             outcome_seen[OUT_FREE]);
    $display("  %0d evictions, %0d repeats, %0d ignored; %0d errors",
             outcome_seen[OUT_EVICT], outcome_seen[OUT_PRESENT],
             outcome_seen[OUT_IGNORED], mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
